// ----- sv/ik_pkg.sv -----
// Shared constants, types and the arctangent table for the two-link arm
// inverse kinematics block. No dependencies.
`default_nettype none
package ik_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CORDIC_ITER_DEF = 16;

    localparam int LINK_W    = 15;
    localparam int DEN_W     = 31;
    localparam int COS_FRAC  = 16;
    localparam int COS_W     = 18;
    localparam int ROOT_W    = 17;
    localparam int RAD_W     = 33;
    localparam int PROD_W    = 34;
    localparam int CORD_W    = 56;
    localparam int ANG_W     = 26;
    localparam int ATAN_W    = 22;
    localparam int SCALE_TOP = 52;
    localparam int SCALE_COS = 18;
    localparam int OUT_SHIFT = 9;

    localparam int THETA1_W = 17;
    localparam int THETA2_W = 15;

    localparam logic [LINK_W-1:0] LINK_RESET = 15'd256;

    typedef enum logic [0:0] {
        REG_LINK_ONE = 1'b0,
        REG_LINK_TWO = 1'b1
    } cfg_idx_t;

    // atan(2^-i) in 2^-16 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:31] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117305,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

endpackage
`default_nettype wire

// ----- sv/ik_front.sv -----
// Front end: squares of the target and link lengths, reach test, and the
// numerator and denominator of cos(theta2). Uses ik_pkg.
`default_nettype none
module ik_front #(
    parameter int COORD_WIDTH = ik_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [COORD_WIDTH-1:0]   in_x,
    input  wire logic signed [COORD_WIDTH-1:0]   in_y,
    input  wire logic [ik_pkg::LINK_W-1:0]       l1,
    input  wire logic [ik_pkg::LINK_W-1:0]       l2,
    output logic                                 out_valid,
    output logic signed [((2*COORD_WIDTH > 32) ? 2*COORD_WIDTH : 32)+1:0] num,
    output logic [ik_pkg::DEN_W-1:0]             den,
    output logic                                 oor,
    output logic signed [COORD_WIDTH-1:0]        out_x,
    output logic signed [COORD_WIDTH-1:0]        out_y
);
    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * CW;
    localparam int CMP_W = (2 * CW > 32) ? 2 * CW : 32;
    localparam int NUM_W = CMP_W + 2;
    localparam int LW    = ik_pkg::LINK_W;

    logic signed [SQ_W-1:0] xx_w, yy_w;
    logic [SQ_W-1:0]        xx_reg, yy_reg;
    logic [2*LW-1:0]        l1sq_reg, l2sq_reg, l1l2_reg;
    logic [LW:0]            lsum_w;
    logic [2*LW+1:0]        reach_reg;
    logic signed [CW-1:0]   x1_reg, y1_reg;
    logic                   v1_reg;

    logic [SQ_W-1:0]         r2_w;
    logic signed [NUM_W-1:0] r2_ext, l1_ext, l2_ext;

    assign xx_w   = in_x * in_x;
    assign yy_w   = in_y * in_y;
    assign lsum_w = (LW+1)'(l1) + (LW+1)'(l2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg    <= SQ_W'($unsigned(xx_w));
            yy_reg    <= SQ_W'($unsigned(yy_w));
            l1sq_reg  <= l1 * l1;
            l2sq_reg  <= l2 * l2;
            l1l2_reg  <= l1 * l2;
            reach_reg <= lsum_w * lsum_w;
            x1_reg    <= in_x;
            y1_reg    <= in_y;
        end
    end

    assign r2_w   = xx_reg + yy_reg;
    assign r2_ext = NUM_W'(r2_w);
    assign l1_ext = NUM_W'(l1sq_reg);
    assign l2_ext = NUM_W'(l2sq_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            oor   <= CMP_W'(r2_w) > CMP_W'(reach_reg);
            num   <= r2_ext - l1_ext - l2_ext;
            den   <= {l1l2_reg, 1'b0};
            out_x <= x1_reg;
            out_y <= y1_reg;
        end
    end

endmodule
`default_nettype wire

// ----- sv/ik_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: forms the rounded,
// clamped cos(theta2) in 2^-16 units. Uses ik_pkg.
`default_nettype none
module ik_div #(
    parameter int NUM_W  = 34,
    parameter int SIDE_W = 33
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [NUM_W-1:0]           num,
    input  wire logic [ik_pkg::DEN_W-1:0]          den,
    input  wire logic [SIDE_W-1:0]                 side_in,
    output logic                                   out_valid,
    output logic signed [ik_pkg::COS_W-1:0]        cos_out,
    output logic [SIDE_W-1:0]                      side_out
);
    localparam int FRAC  = ik_pkg::COS_FRAC;
    localparam int QB    = FRAC + 1;
    localparam int DVD_W = NUM_W + FRAC + 1;
    localparam int DW    = ik_pkg::DEN_W;
    localparam int CSW   = ik_pkg::COS_W;
    localparam logic [QB-1:0]         ONE_Q = QB'(1) << FRAC;
    localparam logic signed [CSW-1:0] ONE_S = CSW'(1) << FRAC;

    logic [NUM_W-1:0] mag_w;
    logic [DVD_W-1:0] dvd_w, den_top_w;

    logic [DVD_W-1:0]  rem_reg  [0:QB];
    logic [QB-1:0]     q_reg    [0:QB];
    logic [DW-1:0]     dv_reg   [0:QB];
    logic              neg_reg  [0:QB];
    logic              big_reg  [0:QB];
    logic              dz_reg   [0:QB];
    logic [SIDE_W-1:0] side_reg [0:QB];
    logic              vld_reg  [0:QB];

    logic [QB-1:0]         qc_w;
    logic signed [CSW-1:0] qs_w, cos_next;

    assign mag_w     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dvd_w     = DVD_W'({mag_w, {FRAC{1'b0}}}) + DVD_W'(den >> 1);
    assign den_top_w = DVD_W'(den) << QB;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= dvd_w;
            q_reg[0]    <= '0;
            dv_reg[0]   <= den;
            neg_reg[0]  <= num[NUM_W-1];
            big_reg[0]  <= dvd_w >= den_top_w;
            dz_reg[0]   <= den == '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int K = QB - 1 - j;
        logic [DVD_W-1:0] trial;
        logic             take;

        assign trial = DVD_W'(dv_reg[j]) << K;
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? rem_reg[j] - trial : rem_reg[j];
                q_reg[j+1]    <= q_reg[j] | (QB'(take) << K);
                dv_reg[j+1]   <= dv_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                big_reg[j+1]  <= big_reg[j];
                dz_reg[j+1]   <= dz_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign qc_w     = (big_reg[QB] || q_reg[QB] > ONE_Q) ? ONE_Q : q_reg[QB];
    assign qs_w     = CSW'(qc_w);
    assign cos_next = dz_reg[QB] ? ONE_S : (neg_reg[QB] ? -qs_w : qs_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_out  <= cos_next;
            side_out <= side_reg[QB];
        end
    end

endmodule
`default_nettype wire

// ----- sv/ik_isqrt.sv -----
// Pipelined integer square root, one root bit per stage: sin(theta2) from
// 2^32 - cos^2. Uses ik_pkg.
`default_nettype none
module ik_isqrt #(
    parameter int SIDE_W = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [ik_pkg::RAD_W-1:0]    rad,
    input  wire logic [SIDE_W-1:0]           side_in,
    output logic                             out_valid,
    output logic [ik_pkg::ROOT_W-1:0]        root,
    output logic [SIDE_W-1:0]                side_out
);
    localparam int RB    = ik_pkg::ROOT_W;
    localparam int REM_W = 2 * RB + 1;

    logic [REM_W-1:0]  rem_reg  [0:RB];
    logic [RB-1:0]     r_reg    [0:RB];
    logic [SIDE_W-1:0] side_reg [0:RB];
    logic              vld_reg  [0:RB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= REM_W'(rad);
            r_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < RB; j++) begin : g_step
        localparam int K = RB - 1 - j;
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = (REM_W'(r_reg[j]) << (K + 1)) + (REM_W'(1) << (2 * K));
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? rem_reg[j] - trial : rem_reg[j];
                r_reg[j+1]    <= r_reg[j] | (RB'(take) << K);
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[RB];
    assign root      = r_reg[RB];
    assign side_out  = side_reg[RB];

endmodule
`default_nettype wire

// ----- sv/ik_cordic.sv -----
// Pipelined vectoring CORDIC, one micro-rotation per stage: atan2(y, x) in
// 2^-16 degree. Uses ik_pkg for widths and the arctangent table.
`default_nettype none
module ik_cordic #(
    parameter int ITER = ik_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [ik_pkg::CORD_W-1:0]  in_y,
    input  wire logic signed [ik_pkg::CORD_W-1:0]  in_x,
    output logic signed [ik_pkg::ANG_W-1:0]        angle
);
    localparam int W  = ik_pkg::CORD_W;
    localparam int AW = ik_pkg::ANG_W;
    localparam logic signed [AW-1:0] QUARTER = AW'(90 * 65536);

    logic signed [W-1:0]  x_reg [0:ITER];
    logic signed [W-1:0]  y_reg [0:ITER];
    logic signed [AW-1:0] z_reg [0:ITER];
    logic                 zr_reg [0:ITER];

    logic signed [W-1:0]  x0_w, y0_w;
    logic signed [AW-1:0] z0_w;

    // quadrant fold for negative x
    always_comb begin
        x0_w = in_x;
        y0_w = in_y;
        z0_w = '0;
        if (in_x < 0) begin
            if (in_y >= 0) begin
                x0_w = in_y;
                y0_w = -in_x;
                z0_w = QUARTER;
            end else begin
                x0_w = -in_y;
                y0_w = in_x;
                z0_w = -QUARTER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= x0_w;
            y_reg[0]  <= y0_w;
            z_reg[0]  <= z0_w;
            zr_reg[0] <= (in_x == '0) && (in_y == '0);
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_rot
        localparam logic signed [AW-1:0] TAB = AW'(ik_pkg::ATAN_TAB[i % 32]);
        logic signed [W-1:0] dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + TAB;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - TAB;
                end
                zr_reg[i+1] <= zr_reg[i];
            end
        end
    end

    assign angle = zr_reg[ITER] ? '0 : z_reg[ITER];

endmodule
`default_nettype wire

// ----- sv/two_link_arm_inverse_kinematics_top.sv -----
// Top level of the two-link arm inverse kinematics block.
// Uses ik_pkg, ik_front, ik_div, ik_isqrt and ik_cordic.
//
// Takes one target word per cycle while the result is not stalled and returns
// one result word per target, in order. The pipeline has two front-end
// stages, 19 divider stages, 18 square-root stages, three CORDIC lanes of
// CORDIC_ITERATIONS + 1 stages, and four glue stages. The whole pipeline
// advances together and holds in place while the result is stalled.
// Link lengths are written through cfg_we/cfg_index/cfg_wdata and are read
// live, so change them only with the pipeline empty.
`default_nettype none
module two_link_arm_inverse_kinematics_top #(
    parameter int COORD_WIDTH       = ik_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = ik_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [ik_pkg::LINK_W-1:0]        cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]    s_target_x,
    input  wire logic signed [COORD_WIDTH-1:0]    s_target_y,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [ik_pkg::THETA1_W-1:0]    m_joint_one_angle,
    output logic [ik_pkg::THETA2_W-1:0]           m_joint_two_angle,
    output logic                                  m_out_of_reach
);
    localparam int CW     = COORD_WIDTH;
    localparam int CMP_W  = (2 * CW > 32) ? 2 * CW : 32;
    localparam int NUM_W  = CMP_W + 2;
    localparam int LW     = ik_pkg::LINK_W;
    localparam int CSW    = ik_pkg::COS_W;
    localparam int PW     = ik_pkg::PROD_W;
    localparam int RW     = ik_pkg::RAD_W;
    localparam int SW     = ik_pkg::ROOT_W;
    localparam int W      = ik_pkg::CORD_W;
    localparam int AW     = ik_pkg::ANG_W;
    localparam int A1_W   = AW + 1;
    localparam int BX_W   = PW + 1;
    localparam int BY_W   = LW + SW;
    localparam int SC1    = ik_pkg::SCALE_TOP - CW;
    localparam int SC2    = ik_pkg::SCALE_COS;
    localparam int CL     = CORDIC_ITERATIONS + 1;
    localparam int DSIDE  = 2 * CW + 1;
    localparam int QSIDE  = DSIDE + CSW + PW;
    localparam int T1W    = ik_pkg::THETA1_W;
    localparam int T2W    = ik_pkg::THETA2_W;

    localparam logic signed [A1_W-1:0] RND    = A1_W'(256);
    localparam logic signed [A1_W-1:0] T1_MIN = -A1_W'(46080);
    localparam logic signed [A1_W-1:0] T1_MAX = A1_W'(23040);
    localparam logic signed [A1_W-1:0] T2_MAX = A1_W'(23040);
    localparam logic signed [2*CSW-1:0] FULL_SQ = (2*CSW)'(1) << (2 * ik_pkg::COS_FRAC);

    logic en;
    logic [LW-1:0] l1_reg, l2_reg;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= ik_pkg::LINK_RESET;
            l2_reg <= ik_pkg::LINK_RESET;
        end else if (cfg_we) begin
            unique case (ik_pkg::cfg_idx_t'(cfg_index))
                ik_pkg::REG_LINK_ONE: l1_reg <= cfg_wdata;
                ik_pkg::REG_LINK_TWO: l2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front end
    logic                    f_valid, f_oor;
    logic signed [NUM_W-1:0] f_num;
    logic [ik_pkg::DEN_W-1:0] f_den;
    logic signed [CW-1:0]    f_x, f_y;

    ik_front #(.COORD_WIDTH(CW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_x      (s_target_x),
        .in_y      (s_target_y),
        .l1        (l1_reg),
        .l2        (l2_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .oor       (f_oor),
        .out_x     (f_x),
        .out_y     (f_y)
    );

    // cos(theta2)
    logic                  d_valid;
    logic signed [CSW-1:0] d_cos;
    logic [DSIDE-1:0]      d_side;

    ik_div #(.NUM_W(NUM_W), .SIDE_W(DSIDE)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side_in   ({f_oor, f_x, f_y}),
        .out_valid (d_valid),
        .cos_out   (d_cos),
        .side_out  (d_side)
    );

    // 2^32 - c^2 and l2*c
    logic signed [2*CSW-1:0] csq_w;
    logic signed [PW-1:0]    p_w;
    logic                    m1_valid_reg;
    logic [RW-1:0]           m1_rad_reg;
    logic [QSIDE-1:0]        m1_side_reg;

    assign csq_w = d_cos * d_cos;
    assign p_w   = $signed({1'b0, l2_reg}) * d_cos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_rad_reg  <= RW'(FULL_SQ - csq_w);
            m1_side_reg <= {d_side, d_cos, p_w};
        end
    end

    // sin(theta2)
    logic             q_valid;
    logic [SW-1:0]    q_sin;
    logic [QSIDE-1:0] q_side;

    ik_isqrt #(.SIDE_W(QSIDE)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m1_valid_reg),
        .rad       (m1_rad_reg),
        .side_in   (m1_side_reg),
        .out_valid (q_valid),
        .root      (q_sin),
        .side_out  (q_side)
    );

    // operands of the second arctangent
    logic signed [BX_W-1:0] l1s_w, bx_w;
    logic signed [PW-1:0]   q_p;
    logic                   m2_valid_reg, m2_oor_reg;
    logic signed [CW-1:0]   m2_x_reg, m2_y_reg;
    logic signed [CSW-1:0]  m2_cos_reg;
    logic [SW-1:0]          m2_sin_reg;
    logic [BY_W-1:0]        m2_by_reg;
    logic signed [BX_W-1:0] m2_bx_reg;

    assign q_p   = q_side[PW-1:0];
    assign l1s_w = BX_W'({l1_reg, {ik_pkg::COS_FRAC{1'b0}}});
    assign bx_w  = l1s_w + BX_W'(q_p);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m2_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_oor_reg <= q_side[QSIDE-1];
            m2_x_reg   <= q_side[QSIDE-2 -: CW];
            m2_y_reg   <= q_side[QSIDE-2-CW -: CW];
            m2_cos_reg <= q_side[PW +: CSW];
            m2_sin_reg <= q_sin;
            m2_by_reg  <= l2_reg * q_sin;
            m2_bx_reg  <= bx_w;
        end
    end

    // three arctangents in parallel
    logic signed [AW-1:0] za_w, zt_w, zb_w;

    ik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_elbow (
        .aclk  (aclk),
        .en    (en),
        .in_y  (W'($signed({1'b0, m2_sin_reg})) <<< SC2),
        .in_x  (W'(m2_cos_reg) <<< SC2),
        .angle (za_w)
    );

    ik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_target (
        .aclk  (aclk),
        .en    (en),
        .in_y  (W'(m2_y_reg) <<< SC1),
        .in_x  (W'(m2_x_reg) <<< SC1),
        .angle (zt_w)
    );

    ik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_offset (
        .aclk  (aclk),
        .en    (en),
        .in_y  (W'($signed({1'b0, m2_by_reg})) <<< SC2),
        .in_x  (W'(m2_bx_reg) <<< SC2),
        .angle (zb_w)
    );

    logic cv_reg [0:CL-1];
    logic co_reg [0:CL-1];

    for (genvar k = 0; k < CL; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k] <= 1'b0;
            end else if (en) begin
                cv_reg[k] <= (k == 0) ? m2_valid_reg : cv_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                co_reg[k] <= (k == 0) ? m2_oor_reg : co_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // angle difference, then rounding and clamping
    logic                   e1_valid_reg, e1_oor_reg;
    logic signed [A1_W-1:0] e1_a1_reg, e1_a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else if (en) begin
            e1_valid_reg <= cv_reg[CL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_oor_reg <= co_reg[CL-1];
            e1_a1_reg  <= A1_W'(zt_w) - A1_W'(zb_w);
            e1_a2_reg  <= A1_W'(za_w);
        end
    end

    logic signed [A1_W-1:0] t1_w, t2_w, t1c_w, t2c_w;

    assign t1_w  = (e1_a1_reg + RND) >>> ik_pkg::OUT_SHIFT;
    assign t2_w  = (e1_a2_reg + RND) >>> ik_pkg::OUT_SHIFT;
    assign t1c_w = (t1_w < T1_MIN) ? T1_MIN : ((t1_w > T1_MAX) ? T1_MAX : t1_w);
    assign t2c_w = (t2_w < 0) ? '0 : ((t2_w > T2_MAX) ? T2_MAX : t2_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_of_reach    <= e1_oor_reg;
            m_joint_one_angle <= e1_oor_reg ? '0 : t1c_w[T1W-1:0];
            m_joint_two_angle <= e1_oor_reg ? '0 : t2c_w[T2W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- sv/ik_checker.sv -----
// Port-level checks for the two-link arm inverse kinematics top level, and
// the bind that attaches them. Uses ik_pkg for field widths.
`default_nettype none
module ik_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [ik_pkg::THETA1_W-1:0]   m_joint_one_angle,
    input wire logic [ik_pkg::THETA2_W-1:0]   m_joint_two_angle,
    input wire logic                          m_out_of_reach
);
    localparam logic signed [ik_pkg::THETA1_W-1:0] T1_LO = -17'sd46080;
    localparam logic signed [ik_pkg::THETA1_W-1:0] T1_HI = 17'sd23040;

    a_reach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_reach |-> m_joint_one_angle == '0 && m_joint_two_angle == '0)
        else $error("out of reach word carries nonzero angles");

    a_elbow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_joint_two_angle <= 15'd23040)
        else $error("joint two angle above 180 degrees");

    a_shoulder_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_joint_one_angle) >= T1_LO && $signed(m_joint_one_angle) <= T1_HI)
        else $error("joint one angle out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_joint_one_angle)
            && $stable(m_joint_two_angle) && $stable(m_out_of_reach))
        else $error("stalled result word changed");

endmodule

bind two_link_arm_inverse_kinematics_top ik_checker u_ik_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_joint_one_angle (m_joint_one_angle),
    .m_joint_two_angle (m_joint_two_angle),
    .m_out_of_reach    (m_out_of_reach)
);
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for two_link_arm_inverse_kinematics_top.
// Depends on ik_pkg and the RTL. It predicts or looks up each result word
// and compares it against the block under random handshake stalls.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [16:0] j1;
        logic [14:0]        j2;
        logic               oor;
    } angles_t;

    typedef struct {
        int      x;
        int      y;
        bit      typed;
        angles_t res;
    } target_row_t;

    localparam int N_DIRECTED = 16;
    localparam int WATCHDOG   = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    ik_pkg::cfg_idx_t cfg_index = ik_pkg::REG_LINK_ONE;
    logic [ik_pkg::LINK_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_target_x = '0;
    logic signed [15:0] s_target_y = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [ik_pkg::THETA1_W-1:0] m_joint_one_angle;
    logic [ik_pkg::THETA2_W-1:0] m_joint_two_angle;
    logic m_out_of_reach;

    longint link_one = 256, link_two = 256;
    angles_t pending_angles[$];
    int mismatches = 0, words_in = 0, words_out = 0, reach_misses = 0;
    bit calm = 0, stall_req = 0;
    int quiet = 0;

    target_row_t directed [N_DIRECTED] = '{
        '{32767, 32767, 1, '{17'sd0, 15'd0, 1'b1}},
        '{-32768, -32768, 1, '{17'sd0, 15'd0, 1'b1}},
        '{32767, -32768, 1, '{17'sd0, 15'd0, 1'b1}},
        '{-32768, 0, 1, '{17'sd0, 15'd0, 1'b1}},
        '{513, 0, 1, '{17'sd0, 15'd0, 1'b1}},
        '{0, 0, 0, '{17'sd0, 15'd0, 1'b0}},
        '{512, 0, 0, '{17'sd0, 15'd0, 1'b0}},
        '{0, 512, 0, '{17'sd0, 15'd0, 1'b0}},
        '{-512, 0, 0, '{17'sd0, 15'd0, 1'b0}},
        '{0, -512, 0, '{17'sd0, 15'd0, 1'b0}},
        '{256, 256, 0, '{17'sd0, 15'd0, 1'b0}},
        '{-300, -100, 0, '{17'sd0, 15'd0, 1'b0}},
        '{-300, 100, 0, '{17'sd0, 15'd0, 1'b0}},
        '{1, -1, 0, '{17'sd0, 15'd0, 1'b0}},
        '{362, 362, 0, '{17'sd0, 15'd0, 1'b0}},
        '{-1, 0, 0, '{17'sd0, 15'd0, 1'b0}}
    };

    two_link_arm_inverse_kinematics_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_target_x(s_target_x), .s_target_y(s_target_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_joint_one_angle(m_joint_one_angle),
        .m_joint_two_angle(m_joint_two_angle),
        .m_out_of_reach(m_out_of_reach)
    );

    always #6 aclk = ~aclk;

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // vectoring CORDIC, 2^-16 degree
    function automatic longint heading(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < ik_pkg::CORDIC_ITER_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ik_pkg::ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ik_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic angles_t solve_arm(longint x, longint y);
        angles_t r;
        longint r2, num, den, c, s, a1, a2, t1, t2, mag, q;
        r2 = x * x + y * y;
        r = '{17'sd0, 15'd0, 1'b0};
        if (r2 > (link_one + link_two) * (link_one + link_two)) begin
            r.oor = 1;
            return r;
        end
        num = r2 - link_one * link_one - link_two * link_two;
        den = 2 * link_one * link_two;
        if (den == 0) begin
            c = 65536;
        end else begin
            mag = num < 0 ? -num : num;
            q = (mag * 65536 + den / 2) / den;
            if (q > 65536) q = 65536;
            c = num < 0 ? -q : q;
        end
        s = root_floor((64'd1 << 32) - c * c);
        a2 = heading(s << 18, c << 18);
        a1 = heading(y << 36, x << 36)
           - heading((link_two * s) << 18, (link_one * 65536 + link_two * c) << 18);
        t1 = (a1 + 256) >>> 9;
        t2 = (a2 + 256) >>> 9;
        if (t1 < -46080) t1 = -46080;
        if (t1 > 23040) t1 = 23040;
        if (t2 < 0) t2 = 0;
        if (t2 > 23040) t2 = 23040;
        r.j1 = t1[16:0];
        r.j2 = t2[14:0];
        return r;
    endfunction

    task automatic send_target(int x, int y, bit typed, angles_t res);
        while (!calm && $urandom_range(99) < 29) begin
            @(negedge aclk);
            s_valid <= 0;
        end
        @(negedge aclk);
        s_valid <= 1;
        s_target_x <= x[15:0];
        s_target_y <= y[15:0];
        do @(posedge aclk); while (!s_ready);
        pending_angles.push_back(typed ? res : solve_arm(longint'(signed'(x[15:0])),
                                                        longint'(signed'(y[15:0]))));
        words_in++;
    endtask

    task automatic drain_and_set(int l1, int l2);
        @(negedge aclk);
        s_valid <= 0;
        while (pending_angles.size() != 0) @(negedge aclk);
        repeat (70) @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= ik_pkg::REG_LINK_ONE;
        cfg_wdata <= l1[14:0];
        @(negedge aclk);
        cfg_index <= ik_pkg::REG_LINK_TWO;
        cfg_wdata <= l2[14:0];
        @(negedge aclk);
        cfg_we <= 0;
        link_one = l1[14:0];
        link_two = l2[14:0];
    endtask

    task automatic random_targets(int n);
        int span, x, y;
        for (int k = 0; k < n; k++) begin
            span = int'(link_one + link_two);
            if (span > 32767) span = 32767;
            if ($urandom_range(99) < 70) begin
                x = $urandom_range(2 * span) - span;
                y = $urandom_range(2 * span) - span;
            end else begin
                x = $urandom_range(65535) - 32768;
                y = $urandom_range(65535) - 32768;
            end
            send_target(x, y, 0, '{17'sd0, 15'd0, 1'b0});
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        for (int k = 0; k < N_DIRECTED; k++)
            send_target(directed[k].x, directed[k].y, directed[k].typed, directed[k].res);
        random_targets(150);
        drain_and_set(1, 1);
        random_targets(100);
        drain_and_set(32767, 32767);
        calm = 1;
        random_targets(120);
        calm = 0;
        drain_and_set(1, 32767);
        stall_req = 1;
        random_targets(150);
        drain_and_set(0, 300);
        random_targets(60);
        drain_and_set(9000, 23000);
        random_targets(100);
        drain_and_set($urandom_range(32767), $urandom_range(32767));
        random_targets(120);
        drain_and_set(256, 256);
        random_targets(130);
        @(negedge aclk);
        s_valid <= 0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("%0d target words sent, %0d results checked (%0d out of reach)",
                 words_in, words_out, reach_misses);
        $display("link settings from zero to full scale, random stalls on both sides");
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready <= 0;
                repeat (200) @(negedge aclk);
                stall_req = 0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
            end
        end
    end

    always @(posedge aclk) begin
        angles_t w;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (m_out_of_reach) reach_misses++;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                w = pending_angles.pop_front();
                if (w.j1 !== m_joint_one_angle || w.j2 !== m_joint_two_angle
                        || w.oor !== m_out_of_reach) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp j1=%0d j2=%0d oor=%0b, got j1=%0d j2=%0d oor=%0b",
                                 w.j1, w.j2, w.oor, m_joint_one_angle,
                                 m_joint_two_angle, m_out_of_reach);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", quiet);
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
`default_nettype wire
